>>> hdl/triangular_toeplitz_inverter_defines.svh
// Assertion macros shared by the triangular Toeplitz inverter RTL.
// Included by the files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef TRIANGULAR_TOEPLITZ_INVERTER_DEFINES_SVH
`define TRIANGULAR_TOEPLITZ_INVERTER_DEFINES_SVH
`ifndef SYNTH
// Check that a property holds on every clock outside reset
`define TTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never occurs outside reset
`define TTI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TTI_ASSERT(lbl, prop, msg)
`define TTI_NEVER(lbl, cond, msg)
`endif
`endif

>>> hdl/ttinv_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the triangular Toeplitz inverter.
// No dependencies; imported by every module of the block.
package ttinv_pkg;

  localparam int MAX_LEN_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;

  // Status codes carried on every result word
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ZERO_PIVOT = 2'd1;
  localparam logic [1:0] ST_SAT        = 2'd2;

  // Datapath operation of one multiply-accumulate slot
  localparam logic [1:0] PH_T = 2'd0;  // t = c * x partial column
  localparam logic [1:0] PH_X = 2'd1;  // x update from x * t
  localparam logic [1:0] PH_P = 2'd2;  // pivot norm

  typedef struct packed {
    logic signed [31:0] coef_re;
    logic signed [31:0] coef_im;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] inv_re;
    logic signed [31:0] inv_im;
    logic               last_entry;
    logic [1:0]         status;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       coef_wr;
    logic       mac_vld;
    logic [1:0] phase;
    logic       first;
    logic       last;
    logic       recip_start;
    logic       recip_sel;
    logic       sat_clr;
    logic       emit_ld;
    logic       last_entry;
  } ttinv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic piv_zero;
    logic recip_done;
    logic out_free;
  } ttinv_sts_t;

endpackage

>>> hdl/ttinv_recip.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider for the pivot reciprocal, one quotient bit per cycle.
// Imports ttinv_pkg but uses none of its items; driven by ttinv_dp.
module ttinv_recip #(
  parameter int FRAC_BITS = 16,
  localparam int TOTAL = 32 + 2 * FRAC_BITS,
  localparam int CW = $clog2(TOTAL)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] mag,
  input  logic        neg,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [34:0] res
);
  import ttinv_pkg::*;

  localparam logic [33:0] QCAP = 34'(1) << 33;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [64:0]   rem_r, rem_nxt;
  logic [33:0]   quo_r, quo_nxt;
  logic [31:0]   mag_r;
  logic          neg_r;
  logic [CW-1:0] bit_idx;
  logic          in_bit;
  logic [64:0]   rem_sh;
  logic [33:0]   quo_sh;
  logic          ge;

  // Next dividend bit: magnitude bits first, then zeros for the 2F fraction shift
  always_comb begin
    bit_idx = cnt_r - CW'(2 * FRAC_BITS);
    in_bit  = (cnt_r >= CW'(2 * FRAC_BITS)) ? mag_r[bit_idx[4:0]] : 1'b0;
    rem_sh  = {rem_r[63:0], in_bit};
    quo_sh  = (quo_r >= QCAP) ? QCAP : {quo_r[32:0], 1'b0};
    ge      = (rem_sh >= {1'b0, den});
  end

  // Step the division
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(TOTAL - 1);
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den}) : rem_sh;
      quo_nxt = (ge && (quo_sh < QCAP)) ? (quo_sh | 34'd1) : quo_sh;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      mag_r <= mag;
      neg_r <= neg;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign res  = neg_r ? (35'd0 - {1'b0, quo_r}) : {1'b0, quo_r};

endmodule

>>> hdl/ttinv_dp.sv
`timescale 1ns / 1ps
`include "triangular_toeplitz_inverter_defines.svh"
// Datapath: coefficient, inverse and scratch memories, complex MAC pipeline,
// saturation, pivot reciprocal and the output word register. Uses ttinv_pkg, ttinv_recip.
module ttinv_dp #(
  parameter int MAX_LEN = 64,
  parameter int FRAC_BITS = 16,
  localparam int AW = $clog2(MAX_LEN),
  localparam int SDEPTH = MAX_LEN / 2,
  localparam int SW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ttinv_pkg::in_word_t   in_data,
  input  ttinv_pkg::ttinv_cmd_t cmd,
  input  logic [AW-1:0]         coef_addr,
  input  logic [AW-1:0]         inv_addr,
  input  logic [SW-1:0]         scr_addr,
  input  logic [AW-1:0]         dst_addr,
  output ttinv_pkg::ttinv_sts_t sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ttinv_pkg::out_word_t  out_data
);
  import ttinv_pkg::*;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // Saturate a wide value to 32 bits; top bit flags overflow
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > S32_MAX)      r = {1'b1, 32'h7FFF_FFFF};
    else if (v < S32_MIN) r = {1'b1, 32'h8000_0000};
    else                  r = {1'b0, v[31:0]};
    return r;
  endfunction

  logic [63:0] coef_mem [MAX_LEN];
  logic [63:0] inv_mem  [MAX_LEN];
  logic [63:0] scr_mem  [SDEPTH];
  logic [63:0] coef_q, inv_q, scr_q;

  // Pipeline tags
  logic          v1_r, v2_r, v3_r;
  logic [1:0]    ph1_r, ph2_r, ph3_r;
  logic          first1_r, first2_r;
  logic          last1_r, last2_r, last3_r;
  logic [AW-1:0] dst1_r, dst2_r, dst3_r;

  logic signed [31:0] a_re, a_im, b_re, b_im;
  logic signed [63:0] prr_r, pii_r, pri_r, pir_r;
  logic signed [63:0] term_re, term_im;
  logic signed [63:0] acc_re_r, acc_im_r, acc_re_nxt, acc_im_nxt;
  logic signed [63:0] res_re, res_im;
  logic [32:0]        sre, sim;
  logic [63:0]        den_r;
  logic signed [31:0] piv_re_r, piv_im_r;
  logic               piv_zero;
  logic               sat_r, sat_nxt;

  logic               rsel_r;
  logic [31:0]        r_mag;
  logic               r_neg;
  logic               r_busy, r_done;
  logic [34:0]        r_res;
  logic [32:0]        r_sat;
  logic [31:0]        rre_r;

  logic               scr_we, mac_inv_we, rcp_inv_we, inv_we;
  logic [AW-1:0]      inv_waddr;
  logic [63:0]        inv_wdata;

  logic               out_vld_r;
  out_word_t          out_data_r;

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.coef_wr) begin
      coef_mem[coef_addr] <= {in_data.coef_im, in_data.coef_re};
    end
    coef_q <= coef_mem[coef_addr];
  end

  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    inv_q <= inv_mem[inv_addr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[dst3_r[SW-1:0]] <= {sim[31:0], sre[31:0]};
    end
    scr_q <= scr_mem[scr_addr];
  end

  // Select multiplier operands by operation
  always_comb begin
    a_re = inv_q[31:0];
    a_im = inv_q[63:32];
    b_re = scr_q[31:0];
    b_im = scr_q[63:32];
    case (ph1_r)
      PH_T: begin
        a_re = coef_q[31:0];
        a_im = coef_q[63:32];
        b_re = inv_q[31:0];
        b_im = inv_q[63:32];
      end
      PH_P: begin
        a_re = coef_q[31:0];
        a_im = coef_q[63:32];
        b_re = coef_q[31:0];
        b_im = coef_q[63:32];
      end
      default: begin
      end
    endcase
  end

  // Floored products and wide accumulation
  always_comb begin
    term_re    = (prr_r >>> FRAC_BITS) - (pii_r >>> FRAC_BITS);
    term_im    = (pri_r >>> FRAC_BITS) + (pir_r >>> FRAC_BITS);
    acc_re_nxt = (first2_r ? 64'sd0 : acc_re_r) + term_re;
    acc_im_nxt = (first2_r ? 64'sd0 : acc_im_r) + term_im;
  end

  // Negate for the inverse update, then saturate
  always_comb begin
    res_re = (ph3_r == PH_X) ? -acc_re_r : acc_re_r;
    res_im = (ph3_r == PH_X) ? -acc_im_r : acc_im_r;
    sre    = sat32(res_re);
    sim    = sat32(res_im);
    r_sat  = sat32({{29{r_res[34]}}, r_res});
  end

  // Write steering for the scratch and inverse memories
  always_comb begin
    scr_we     = v3_r && last3_r && (ph3_r == PH_T);
    mac_inv_we = v3_r && last3_r && (ph3_r == PH_X);
    rcp_inv_we = r_done && rsel_r;
    inv_we     = mac_inv_we || rcp_inv_we;
    inv_waddr  = mac_inv_we ? dst3_r : '0;
    inv_wdata  = mac_inv_we ? {sim[31:0], sre[31:0]} : {r_sat[31:0], rre_r};
  end

  // Saturation status for the column
  always_comb begin
    sat_nxt = sat_r;
    if (cmd.sat_clr) begin
      sat_nxt = 1'b0;
    end else if ((scr_we || mac_inv_we) && (sre[32] || sim[32])) begin
      sat_nxt = 1'b1;
    end else if (r_done && r_sat[32]) begin
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      v1_r  <= cmd.mac_vld;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      sat_r <= sat_nxt;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    ph1_r    <= cmd.phase;
    first1_r <= cmd.first;
    last1_r  <= cmd.last;
    dst1_r   <= dst_addr;
    ph2_r    <= ph1_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    dst2_r   <= dst1_r;
    ph3_r    <= ph2_r;
    last3_r  <= last2_r;
    dst3_r   <= dst2_r;
    prr_r    <= 64'(a_re) * 64'(b_re);
    pii_r    <= 64'(a_im) * 64'(b_im);
    pri_r    <= 64'(a_re) * 64'(b_im);
    pir_r    <= 64'(a_im) * 64'(b_re);
    if (v2_r) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
    if (v1_r && (ph1_r == PH_P)) begin
      piv_re_r <= coef_q[31:0];
      piv_im_r <= coef_q[63:32];
    end
    if (v2_r && (ph2_r == PH_P)) begin
      den_r <= prr_r + pii_r;
    end
    if (cmd.recip_start) begin
      rsel_r <= cmd.recip_sel;
    end
    if (r_done && !rsel_r) begin
      rre_r <= r_sat[31:0];
    end
  end

  // Reciprocal operand: real part from A, imaginary part from -B
  always_comb begin
    if (cmd.recip_sel) begin
      r_neg = !piv_im_r[31] && (piv_im_r != 32'sd0);
      r_mag = piv_im_r[31] ? (32'd0 - piv_im_r) : piv_im_r;
    end else begin
      r_neg = piv_re_r[31];
      r_mag = piv_re_r[31] ? (32'd0 - piv_re_r) : piv_re_r;
    end
  end

  ttinv_recip #(
    .FRAC_BITS(FRAC_BITS)
  ) u_recip (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.recip_start),
    .mag  (r_mag),
    .neg  (r_neg),
    .den  (den_r),
    .busy (r_busy),
    .done (r_done),
    .res  (r_res)
  );

  assign piv_zero = (piv_re_r == 32'sd0) && (piv_im_r == 32'sd0);

  // Output word register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_data_r.inv_re     <= piv_zero ? 32'sd0 : inv_q[31:0];
      out_data_r.inv_im     <= piv_zero ? 32'sd0 : inv_q[63:32];
      out_data_r.last_entry <= cmd.last_entry;
      out_data_r.status     <= piv_zero ? ST_ZERO_PIVOT : (sat_r ? ST_SAT : ST_OK);
    end
  end

  assign out_valid      = out_vld_r;
  assign out_data       = out_data_r;
  assign sts.piv_zero   = piv_zero;
  assign sts.recip_done = r_done;
  assign sts.out_free   = !out_vld_r;

  `TTI_NEVER(a_inv_wr_clash, mac_inv_we && rcp_inv_we, "inverse memory write clash")
  `TTI_ASSERT(a_out_ld_empty, cmd.emit_ld |-> !out_vld_r, "output word overwritten")
  `TTI_ASSERT(a_recip_idle, cmd.recip_start |-> !r_busy, "reciprocal restarted while busy")
  `TTI_NEVER(a_x_after_t, cmd.mac_vld && (cmd.phase == PH_X) && ((v1_r && (ph1_r == PH_T)) || (v2_r && (ph2_r == PH_T)) || (v3_r && (ph3_r == PH_T))), "x step issued before t drained")

endmodule

>>> hdl/ttinv_ctrl.sv
`timescale 1ns / 1ps
// Controller: load counter, length register, doubling loop sequencer and emit sequencer.
// Uses ttinv_pkg; drives ttinv_dp through command and status structs.
module ttinv_ctrl #(
  parameter int MAX_LEN = 64,
  localparam int AW = $clog2(MAX_LEN),
  localparam int SDEPTH = MAX_LEN / 2,
  localparam int SW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_wr_data,
  output ttinv_pkg::ttinv_cmd_t cmd,
  output logic [AW-1:0]         coef_addr,
  output logic [AW-1:0]         inv_addr,
  output logic [SW-1:0]         scr_addr,
  output logic [AW-1:0]         dst_addr,
  input  ttinv_pkg::ttinv_sts_t sts
);
  import ttinv_pkg::*;

  localparam int LOG_MAX = $clog2(MAX_LEN + 1) - 1;
  localparam logic [2:0] DRAIN_CYC = 3'd4;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_PIV   = 4'd1;
  localparam logic [3:0] S_PWAIT = 4'd2;
  localparam logic [3:0] S_RRE   = 4'd3;
  localparam logic [3:0] S_RREW  = 4'd4;
  localparam logic [3:0] S_RIM   = 4'd5;
  localparam logic [3:0] S_RIMW  = 4'd6;
  localparam logic [3:0] S_MAC   = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_EMRD  = 4'd9;
  localparam logic [3:0] S_EMLD  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [2:0]    size_log2_r, size_log2_nxt;
  logic [AW-1:0] load_cnt_r, load_cnt_nxt;
  logic [AW:0]   m_r, m_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    drain_r, drain_nxt;
  logic [3:0]    log_eff;
  logic [AW:0]   len;
  logic          in_acc;
  logic          row_last;
  logic [AW:0]   cidx;

  // Column length, clamped to the largest power of two that fits
  always_comb begin
    log_eff = ({1'b0, size_log2_r} > 4'(LOG_MAX)) ? 4'(LOG_MAX) : {1'b0, size_log2_r};
    len     = (AW + 1)'(1) << log_eff;
  end

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign row_last = (phase_r == PH_T) ? ({1'b0, j_r} == m_r - (AW + 1)'(1)) : (j_r == i_r);
  assign cidx     = m_r + {1'b0, i_r} - {1'b0, j_r};

  always_comb begin
    state_nxt     = state_r;
    size_log2_nxt = size_log2_r;
    load_cnt_nxt  = load_cnt_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    phase_nxt     = phase_r;
    drain_nxt     = drain_r;
    cmd           = '0;
    coef_addr     = '0;
    inv_addr      = '0;
    scr_addr      = '0;
    dst_addr      = '0;
    unique case (state_r)
      // Store words until the column is complete
      S_LOAD: begin
        coef_addr   = load_cnt_r;
        cmd.coef_wr = in_acc;
        if (in_acc) begin
          if ({1'b0, load_cnt_r} + (AW + 1)'(1) == len) begin
            load_cnt_nxt = '0;
            state_nxt    = S_PIV;
          end else begin
            load_cnt_nxt = load_cnt_r + AW'(1);
          end
        end
        if (cfg_wr_en) begin
          size_log2_nxt = cfg_wr_data;
          load_cnt_nxt  = '0;
        end
      end
      // Read the pivot and form its norm
      S_PIV: begin
        cmd.mac_vld = 1'b1;
        cmd.phase   = PH_P;
        cmd.first   = 1'b1;
        cmd.sat_clr = 1'b1;
        drain_nxt   = DRAIN_CYC;
        state_nxt   = S_PWAIT;
      end
      S_PWAIT: begin
        if (drain_r != 3'd0) begin
          drain_nxt = drain_r - 3'd1;
        end else if (sts.piv_zero) begin
          k_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          state_nxt = S_RRE;
        end
      end
      S_RRE: begin
        cmd.recip_start = 1'b1;
        state_nxt       = S_RREW;
      end
      S_RREW: begin
        if (sts.recip_done) begin
          state_nxt = S_RIM;
        end
      end
      S_RIM: begin
        cmd.recip_start = 1'b1;
        cmd.recip_sel   = 1'b1;
        state_nxt       = S_RIMW;
      end
      S_RIMW: begin
        cmd.recip_sel = 1'b1;
        if (sts.recip_done) begin
          if (len == (AW + 1)'(1)) begin
            k_nxt     = '0;
            state_nxt = S_EMRD;
          end else begin
            m_nxt     = (AW + 1)'(1);
            i_nxt     = '0;
            j_nxt     = '0;
            phase_nxt = PH_T;
            state_nxt = S_MAC;
          end
        end
      end
      // One complex MAC per cycle over the rows of the current half
      S_MAC: begin
        cmd.mac_vld = 1'b1;
        cmd.phase   = phase_r;
        cmd.first   = (j_r == '0);
        cmd.last    = row_last;
        coef_addr   = cidx[AW-1:0];
        scr_addr    = j_r[SW-1:0];
        if (phase_r == PH_T) begin
          inv_addr = j_r;
          dst_addr = i_r;
        end else begin
          inv_addr = i_r - j_r;
          dst_addr = m_r[AW-1:0] + i_r;
        end
        if (row_last) begin
          j_nxt = '0;
          if ({1'b0, i_r} == m_r - (AW + 1)'(1)) begin
            drain_nxt = DRAIN_CYC;
            state_nxt = S_DRAIN;
          end else begin
            i_nxt = i_r + AW'(1);
          end
        end else begin
          j_nxt = j_r + AW'(1);
        end
      end
      // Let results land before they are read back
      S_DRAIN: begin
        if (drain_r != 3'd0) begin
          drain_nxt = drain_r - 3'd1;
        end else if (phase_r == PH_T) begin
          phase_nxt = PH_X;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_MAC;
        end else if ((m_r << 1) == len) begin
          k_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          m_nxt     = m_r << 1;
          phase_nxt = PH_T;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_MAC;
        end
      end
      // Read one inverse entry once the output word is free
      S_EMRD: begin
        inv_addr = k_r;
        if (sts.out_free) begin
          state_nxt = S_EMLD;
        end
      end
      S_EMLD: begin
        inv_addr       = k_r;
        cmd.emit_ld    = 1'b1;
        cmd.last_entry = ({1'b0, k_r} == len - (AW + 1)'(1));
        if ({1'b0, k_r} == len - (AW + 1)'(1)) begin
          state_nxt = S_LOAD;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = S_EMRD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      size_log2_r <= 3'd6;
      load_cnt_r  <= '0;
      drain_r     <= 3'd0;
    end else begin
      state_r     <= state_nxt;
      size_log2_r <= size_log2_nxt;
      load_cnt_r  <= load_cnt_nxt;
      drain_r     <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    phase_r <= phase_nxt;
  end

endmodule

>>> hdl/triangular_toeplitz_inverter.sv
`timescale 1ns / 1ps
// Top level of the triangular Toeplitz inverter: controller plus datapath.
// Uses ttinv_pkg, ttinv_ctrl, ttinv_dp (and ttinv_recip below it).
//
// Loads L = 2^size_log2 complex Q16.16 words (clamped to MAX_LEN), one per cycle, then
// computes the inverse column by Newton doubling and emits L result words, the last one
// marked. The pivot reciprocal is found by a bit-serial divider, run once for the real
// and once for the imaginary part. Each doubling step of half size m runs m*m products
// and then m*(m+1)/2 products on the single complex MAC (four 32x32 multipliers, one
// product set per cycle), each half followed by a drain. Emitting waits for the output
// word to empty before the next entry is read. No input is taken while computing or
// emitting, except that loading of the next column starts while the last result word
// still waits. Writing size_log2 during loading restarts loading; other states ignore
// it. No clearing pass follows reset.
module triangular_toeplitz_inverter #(
  parameter int MAX_LEN = ttinv_pkg::MAX_LEN_DEF,
  parameter int FRAC_BITS = ttinv_pkg::FRAC_BITS_DEF,
  localparam int AW = $clog2(MAX_LEN),
  localparam int SDEPTH = MAX_LEN / 2,
  localparam int SW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ttinv_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ttinv_pkg::out_word_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_wr_data
);
  import ttinv_pkg::*;

  ttinv_cmd_t    cmd;
  ttinv_sts_t    sts;
  logic [AW-1:0] coef_addr, inv_addr, dst_addr;
  logic [SW-1:0] scr_addr;

  ttinv_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .coef_addr  (coef_addr),
    .inv_addr   (inv_addr),
    .scr_addr   (scr_addr),
    .dst_addr   (dst_addr),
    .sts        (sts)
  );

  ttinv_dp #(
    .MAX_LEN  (MAX_LEN),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .coef_addr(coef_addr),
    .inv_addr (inv_addr),
    .scr_addr (scr_addr),
    .dst_addr (dst_addr),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
